>>> design/dgss_pkg.sv
// Shared types, mode codes and word packing for the dual game pad serial shifter.
// No dependencies; imported by every module of the block.
`default_nettype none

package dgss_pkg;

  // Pad type codes held in the port mode registers
  localparam logic [1:0] MODE_NONE = 2'd0;
  localparam logic [1:0] MODE_NES  = 2'd1;
  localparam logic [1:0] MODE_SNES = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_PORT0_MODE = 2'd0;
  localparam logic [1:0] REG_PORT1_MODE = 2'd1;

  localparam int WORD_BITS   = 16;
  localparam int BUTTON_BITS = 12;

  localparam logic [WORD_BITS-1:0] SNES_FILL = 16'hF000;
  localparam logic [WORD_BITS-1:0] IDLE_WORD = 16'hFFFF;

  typedef logic [1:0]             mode_t;
  typedef logic [BUTTON_BITS-1:0] buttons_t;
  typedef logic [WORD_BITS-1:0]   word_t;

  // Per-step lane commands from the sequencer
  typedef struct packed {
    logic load;
    logic advance;
    logic finish;
  } lane_ctl_t;

  function automatic logic is_connected(input mode_t mode);
    return (mode == MODE_NES) || (mode == MODE_SNES);
  endfunction

  // Active-low word, bit 0 goes out first
  function automatic word_t pack_word(input mode_t mode, input buttons_t buttons);
    buttons_t released;
    released = ~buttons;
    case (mode)
      MODE_SNES: pack_word = SNES_FILL | {4'h0, released};
      MODE_NES:  pack_word = {8'h00, released[7:0]};
      default:   pack_word = IDLE_WORD;
    endcase
  endfunction

endpackage

`default_nettype wire

>>> design/dual_gamepad_serial_shifter_core.sv
// The result of an input transfer is held in the output register from the following cycle.
// Throughput: one item per cycle while no result is held up by out_stall; the result register frees as it drains.
// Each sample runs through the sequencer and both lanes in a single register step.
// Synchronous active-high reset clears the modes, sequencer state, data levels
// and the output valid flag. Top level; depends on dgss_pkg, dgss_seq, dgss_lane.
`default_nettype none

module dual_gamepad_serial_shifter_core #(
  parameter int FRAME_BITS = 16
) (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       cfg_we,
  input  wire  [1:0]                cfg_index,
  input  wire  [1:0]                cfg_data,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire                       latch_line,
  input  wire                       clock_line,
  input  wire  [11:0]               pad0_buttons,
  input  wire  [11:0]               pad1_buttons,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic                      port0_data,
  output logic                      port1_data
);
  import dgss_pkg::*;

  localparam int CW = $clog2(FRAME_BITS + 1);

  mode_t     port0_mode;
  mode_t     port1_mode;
  logic      accept;
  lane_ctl_t ctl;
  logic      busy;
  logic [CW-1:0] count;
  logic      bit0;
  logic      bit1;

  // Take a new sample unless a result is held up downstream
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      port0_mode <= MODE_NONE;
      port1_mode <= MODE_NONE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PORT0_MODE: port0_mode <= cfg_data;
        REG_PORT1_MODE: port1_mode <= cfg_data;
        default: ;
      endcase
    end
  end

  dgss_seq #(
    .FRAME_BITS(FRAME_BITS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .latch_line (latch_line),
    .clock_line (clock_line),
    .ctl        (ctl),
    .busy       (busy),
    .count      (count)
  );

  dgss_lane u_lane0 (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .mode     (port0_mode),
    .buttons  (pad0_buttons),
    .port_bit (bit0)
  );

  dgss_lane u_lane1 (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .mode     (port1_mode),
    .buttons  (pad1_buttons),
    .port_bit (bit1)
  );

  // Result register: load on transfer, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      port0_data <= bit0;
      port1_data <= bit1;
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count < CW'(FRAME_BITS))
    else $error("edge count reached frame length");

  a_idle_count: assert property (@(posedge clk) disable iff (rst)
    !busy |-> count == '0)
    else $error("edge count nonzero while idle");

  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    ctl.load |=> busy)
    else $error("load did not start a frame");

  a_ctl_excl: assert property (@(posedge clk) disable iff (rst)
    $onehot0({ctl.load, ctl.advance, ctl.finish}))
    else $error("conflicting lane commands");
`endif

endmodule

`default_nettype wire

>>> design/dgss_seq.sv
// Link sequencer: tracks latch, clock edges and the frame bit count.
// Depends on dgss_pkg for the lane command struct.
`default_nettype none

module dgss_seq #(
  parameter int FRAME_BITS = 16
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 accept,
  input  wire                 latch_line,
  input  wire                 clock_line,
  output dgss_pkg::lane_ctl_t ctl,
  output logic                busy,
  output logic [$clog2(FRAME_BITS+1)-1:0] count
);
  import dgss_pkg::*;

  localparam int CW = $clog2(FRAME_BITS + 1);

  logic          prev_clock;
  logic [CW-1:0] count_inc;
  logic          rise;
  logic          watch;

  assign count_inc = count + CW'(1);
  // Clock is watched only while shifting with latch low
  assign watch     = accept && busy && !latch_line && (clock_line != prev_clock);
  assign rise      = watch && clock_line;

  // Decode the step into lane commands
  always_comb begin
    ctl.load    = accept && !busy && latch_line;
    ctl.advance = rise && (count_inc < CW'(FRAME_BITS));
    ctl.finish  = rise && !(count_inc < CW'(FRAME_BITS));
  end

  // Update busy flag, last clock level and edge count
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      prev_clock <= 1'b0;
      count      <= '0;
    end else begin
      if (ctl.load) begin
        busy       <= 1'b1;
        prev_clock <= clock_line;
        count      <= '0;
      end else if (watch) begin
        prev_clock <= clock_line;
        if (ctl.advance) begin
          count <= count_inc;
        end else if (ctl.finish) begin
          busy  <= 1'b0;
          count <= '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> design/dgss_lane.sv
// One pad port: shift word, presented data level and the output bit.
// Depends on dgss_pkg for packing and the lane command struct.
`default_nettype none

module dgss_lane (
  input  wire                 clk,
  input  wire                 rst,
  input  dgss_pkg::lane_ctl_t ctl,
  input  dgss_pkg::mode_t     mode,
  input  dgss_pkg::buttons_t  buttons,
  output logic                port_bit
);
  import dgss_pkg::*;

  word_t shift_word;
  word_t shift_word_next;
  word_t loaded;
  logic  data_level;
  logic  data_level_next;

  assign loaded = pack_word(mode, buttons);

  // Select the word and level after this step
  always_comb begin
    shift_word_next = shift_word;
    data_level_next = data_level;
    if (ctl.load) begin
      data_level_next = loaded[0];
      shift_word_next = loaded >> 1;
    end else if (ctl.advance) begin
      data_level_next = shift_word[0];
      shift_word_next = shift_word >> 1;
    end else if (ctl.finish) begin
      data_level_next = 1'b0;
    end
  end

  // A port with no pad drives high
  assign port_bit = is_connected(mode) ? data_level_next : 1'b1;

  always_ff @(posedge clk) begin
    shift_word <= shift_word_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      data_level <= 1'b0;
    end else begin
      data_level <= data_level_next;
    end
  end

endmodule

`default_nettype wire
